/* sv/twelve_hour_clock_with_knob_set_macros.svh */
// assertion helpers shared by the clock block
`ifndef TWELVE_HOUR_CLOCK_WITH_KNOB_SET_MACROS_SVH
`define TWELVE_HOUR_CLOCK_WITH_KNOB_SET_MACROS_SVH

// same-cycle implication, off while reset is held
`define THC_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define THC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/thc_pkg.sv */
package thc_pkg;

    // tick beats that make up one minute
    localparam int TICKS_PER_MINUTE = 60;

    localparam logic [3:0] HOUR_MAX   = 4'd12;
    localparam logic [3:0] HOUR_MIN   = 4'd1;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    // one decimal value split into tens and ones
    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] ones;
    } digits_t;

    // segments a..h of one digit, segment a in bit 7; blank past nine
    function automatic logic [7:0] seg_fwd(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'b1110_1101;
            4'd1:    seg = 8'b0000_0101;
            4'd2:    seg = 8'b1101_1100;
            4'd3:    seg = 8'b1001_1101;
            4'd4:    seg = 8'b0011_0101;
            4'd5:    seg = 8'b1011_1001;
            4'd6:    seg = 8'b1111_1001;
            4'd7:    seg = 8'b0000_1101;
            4'd8:    seg = 8'b1111_1101;
            4'd9:    seg = 8'b1011_1101;
            default: seg = 8'b0000_0000;
        endcase
        return seg;
    endfunction

    // segments h..a of one digit, segment h in bit 7
    function automatic logic [7:0] seg_rev(input logic [3:0] digit);
        logic [7:0] fwd;
        logic [7:0] rev;
        fwd = seg_fwd(digit);
        for (int i = 0; i < 8; i++) begin
            rev[i] = fwd[7 - i];
        end
        return rev;
    endfunction

    // decimal split of a value below 64
    function automatic digits_t dec_split(input logic [5:0] v);
        digits_t    d;
        logic [5:0] rest;
        if (v >= 6'd60)      d.tens = 3'd6;
        else if (v >= 6'd50) d.tens = 3'd5;
        else if (v >= 6'd40) d.tens = 3'd4;
        else if (v >= 6'd30) d.tens = 3'd3;
        else if (v >= 6'd20) d.tens = 3'd2;
        else if (v >= 6'd10) d.tens = 3'd1;
        else                 d.tens = 3'd0;
        rest   = v - {3'd0, d.tens} * 6'd10;
        d.ones = rest[3:0];
        return d;
    endfunction

endpackage

/* sv/twelve_hour_clock_with_knob_set.sv */
// Twelve-hour clock set by an hour knob and a minute knob. Each input beat is one poll of
// the four knob pins plus a one-second tick flag, and each beat yields exactly one result
// beat with the hour, the minute, the 40-bit display frame (bit 39 shifted out first) and
// an update flag that is high when the time changed. The first beat after reset only
// records the pins. The block takes one beat per cycle while the receiver accepts results: the
// beat is held in an input register, then one pass of counter update and segment lookup
// fills the result register; the counters update in that same pass, which sets the rate.
module twelve_hour_clock_with_knob_set (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // hour_knob_a, hour_knob_b, minute_knob_a, minute_knob_b, second_tick, 3 zero bits
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hour_value[3:0], minute_value[9:4], segment_frame[49:10], frame_update[50], 5 zero bits
    output logic [55:0] m_tdata
);

    // input register
    logic       in_valid_reg;
    logic [4:0] in_data_reg;

    // clock state
    logic [3:0] hour_reg,   hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [3:0] pins_reg;
    logic       primed_reg;

    // result register
    logic        out_valid_reg;
    logic [3:0]  res_hour_reg;
    logic [5:0]  res_minute_reg;
    logic [39:0] res_frame_reg, frame_next;
    logic        res_update_reg, update_next;

    logic out_free;
    logic adv;

    assign out_free = !out_valid_reg || m_tready;
    assign adv      = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // knob edge decode and counter update
    logic       ha, hb, ma, mb, tick;
    logic       h_dn, h_up, m_dn, m_up;
    logic [3:0] hour_k;
    logic [5:0] minute_k;
    logic       tick_en, sec_wrap, min_wrap;
    logic [6:0] sec_sum;

    always_comb begin
        ha   = in_data_reg[0];
        hb   = in_data_reg[1];
        ma   = in_data_reg[2];
        mb   = in_data_reg[3];
        tick = in_data_reg[4];

        h_dn = primed_reg && ha && !pins_reg[0] && hb;
        h_up = primed_reg && !h_dn && hb && !pins_reg[1] && ha;
        m_dn = primed_reg && ma && !pins_reg[2] && mb;
        m_up = primed_reg && !m_dn && mb && !pins_reg[3] && ma;

        if (h_dn) begin
            hour_k = (hour_reg <= thc_pkg::HOUR_MIN) ? thc_pkg::HOUR_MAX : hour_reg - 4'd1;
        end else if (h_up) begin
            hour_k = (hour_reg >= thc_pkg::HOUR_MAX) ? thc_pkg::HOUR_MIN : hour_reg + 4'd1;
        end else begin
            hour_k = hour_reg;
        end

        if (m_dn) begin
            minute_k = (minute_reg == 6'd0) ? thc_pkg::MINUTE_MAX : minute_reg - 6'd1;
        end else if (m_up) begin
            minute_k = (minute_reg >= thc_pkg::MINUTE_MAX) ? 6'd0 : minute_reg + 6'd1;
        end else begin
            minute_k = minute_reg;
        end

        // second tick, carried into minute and hour
        tick_en  = primed_reg && tick;
        sec_sum  = {1'b0, second_reg} + 7'd1;
        sec_wrap = tick_en && (sec_sum >= 7'(thc_pkg::TICKS_PER_MINUTE));
        min_wrap = minute_k >= thc_pkg::MINUTE_MAX;

        if (!tick_en)      second_next = second_reg;
        else if (sec_wrap) second_next = 6'd0;
        else               second_next = sec_sum[5:0];

        if (sec_wrap) begin
            minute_next = min_wrap ? 6'd0 : minute_k + 6'd1;
        end else begin
            minute_next = minute_k;
        end

        if (sec_wrap && min_wrap) begin
            hour_next = (hour_k >= thc_pkg::HOUR_MAX) ? thc_pkg::HOUR_MIN : hour_k + 4'd1;
        end else begin
            hour_next = hour_k;
        end

        update_next = h_dn || h_up || m_dn || m_up || sec_wrap;
    end

    // display frame from the updated time
    thc_pkg::digits_t hour_dig, minute_dig;
    logic [7:0]       hour_tens_seg;

    always_comb begin
        hour_dig      = thc_pkg::dec_split({2'b00, hour_next});
        minute_dig    = thc_pkg::dec_split(minute_next);
        hour_tens_seg = (hour_dig.tens == 3'd0) ? 8'd0
                        : thc_pkg::seg_rev({1'b0, hour_dig.tens});
        frame_next = {4'd0,
                      thc_pkg::seg_fwd({1'b0, minute_dig.tens}),
                      thc_pkg::seg_fwd(minute_dig.ones),
                      4'd0,
                      thc_pkg::seg_rev(hour_dig.ones),
                      hour_tens_seg};
    end

    // input beat capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[4:0];
        end
    end

    // clock state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_reg   <= thc_pkg::HOUR_MAX;
            minute_reg <= 6'd0;
            second_reg <= 6'd0;
            pins_reg   <= 4'd0;
            primed_reg <= 1'b0;
        end else if (adv) begin
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            pins_reg   <= in_data_reg[3:0];
            primed_reg <= 1'b1;
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
        if (adv) begin
            res_hour_reg   <= hour_next;
            res_minute_reg <= minute_next;
            res_frame_reg  <= frame_next;
            res_update_reg <= update_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, res_update_reg, res_frame_reg, res_minute_reg, res_hour_reg};

`include "twelve_hour_clock_with_knob_set_macros.svh"

    `THC_ASSERT_IMPLY(a_hour_range, 1'b1, hour_reg >= 4'd1 && hour_reg <= 4'd12, "hour out of range")
    `THC_ASSERT_IMPLY(a_minute_range, 1'b1, minute_reg <= 6'd59, "minute out of range")
    `THC_ASSERT_NEXT(a_first_quiet, adv && !primed_reg, !res_update_reg, "update on first beat")
    `THC_ASSERT_IMPLY(a_no_overrun, in_valid_reg && out_valid_reg && !m_tready, !s_tready, "overrun")

endmodule

/* bench/twelve_hour_clock_with_knob_set_tb.sv */
module twelve_hour_clock_with_knob_set_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 2000;
    localparam int POLL_TARGET  = 770;
    localparam int SETTLE_TICKS = 8;

    // segments a..h of each decimal digit, segment a in bit 7
    localparam logic [7:0] DIGIT_SEGMENTS [10] = '{
        8'b1110_1101, 8'b0000_0101, 8'b1101_1100, 8'b1001_1101, 8'b0011_0101,
        8'b1011_1001, 8'b1111_1001, 8'b0000_1101, 8'b1111_1101, 8'b1011_1101
    };

    typedef enum logic [1:0] {KNOB_HOLD, KNOB_UP, KNOB_DOWN} knob_move_e;

    // one poll beat, hour_knob_a in the lowest bit
    typedef struct packed {
        logic second_tick;
        logic minute_knob_b;
        logic minute_knob_a;
        logic hour_knob_b;
        logic hour_knob_a;
    } poll_t;

    // one display beat, hour_value in the lowest bits
    typedef struct packed {
        logic        frame_update;
        logic [39:0] segment_frame;
        logic [5:0]  minute_value;
        logic [3:0]  hour_value;
    } clock_display_t;

    // tracks the expected time and compares each display beat against it
    class clock_scoreboard;
        logic [3:0]     hour_now;
        logic [5:0]     minute_now;
        logic [5:0]     second_now;
        logic [1:0]     hour_pins_was;
        logic [1:0]     minute_pins_was;
        bit             primed;
        clock_display_t pending_displays[$];
        int             mismatches;

        function new();
            hour_now        = thc_pkg::HOUR_MAX;
            minute_now      = '0;
            second_now      = '0;
            hour_pins_was   = '0;
            minute_pins_was = '0;
            primed          = 1'b0;
            mismatches      = 0;
        endfunction

        // a rise on a with b high turns down, else a rise on b with a high turns up
        function knob_move_e sense_knob(logic a, logic b, logic pa, logic pb);
            if (a && !pa && b) return KNOB_DOWN;
            if (b && !pb && a) return KNOB_UP;
            return KNOB_HOLD;
        endfunction

        function void hour_step(knob_move_e dir);
            if (dir == KNOB_UP)
                hour_now = (hour_now >= thc_pkg::HOUR_MAX) ? thc_pkg::HOUR_MIN
                                                           : hour_now + 4'd1;
            else if (dir == KNOB_DOWN)
                hour_now = (hour_now <= thc_pkg::HOUR_MIN) ? thc_pkg::HOUR_MAX
                                                           : hour_now - 4'd1;
        endfunction

        // returns 1 when the minute wrapped upward
        function bit minute_step(knob_move_e dir);
            if (dir == KNOB_UP) begin
                if (minute_now >= thc_pkg::MINUTE_MAX) begin
                    minute_now = '0;
                    return 1'b1;
                end
                minute_now = minute_now + 6'd1;
            end else if (dir == KNOB_DOWN) begin
                minute_now = (minute_now == '0) ? thc_pkg::MINUTE_MAX : minute_now - 6'd1;
            end
            return 1'b0;
        endfunction

        function logic [7:0] segments_ah(int digit);
            return (digit >= 0 && digit <= 9) ? DIGIT_SEGMENTS[digit] : 8'h00;
        endfunction

        function logic [7:0] segments_ha(int digit);
            logic [7:0] fwd;
            logic [7:0] rev;
            fwd = segments_ah(digit);
            for (int i = 0; i < 8; i++) rev[i] = fwd[7 - i];
            return rev;
        endfunction

        // shift order from bit 39: pad, minute digits, pad, hour ones, hour tens
        function logic [39:0] display_frame();
            int h;
            int m;
            h = hour_now;
            m = minute_now;
            return {4'b0000, segments_ah(m / 10), segments_ah(m % 10), 4'b0000,
                    segments_ha(h % 10), (h / 10 == 0) ? 8'h00 : segments_ha(h / 10)};
        endfunction

        function clock_display_t advance_clock(poll_t p);
            clock_display_t d;
            bit             changed;
            knob_move_e     hour_move;
            knob_move_e     minute_move;
            changed = 1'b0;
            if (primed) begin
                hour_move   = sense_knob(p.hour_knob_a, p.hour_knob_b,
                                         hour_pins_was[1], hour_pins_was[0]);
                minute_move = sense_knob(p.minute_knob_a, p.minute_knob_b,
                                         minute_pins_was[1], minute_pins_was[0]);
                if (hour_move != KNOB_HOLD) begin
                    hour_step(hour_move);
                    changed = 1'b1;
                end
                if (minute_move != KNOB_HOLD) begin
                    void'(minute_step(minute_move));
                    changed = 1'b1;
                end
                // tick comes after the knobs, a minute wrap carries into the hour
                if (p.second_tick) begin
                    if (int'(second_now) + 1 >= thc_pkg::TICKS_PER_MINUTE) begin
                        second_now = '0;
                        if (minute_step(KNOB_UP)) hour_step(KNOB_UP);
                        changed = 1'b1;
                    end else begin
                        second_now = second_now + 6'd1;
                    end
                end
            end
            hour_pins_was   = {p.hour_knob_a, p.hour_knob_b};
            minute_pins_was = {p.minute_knob_a, p.minute_knob_b};
            primed          = 1'b1;
            d.hour_value    = hour_now;
            d.minute_value  = minute_now;
            d.segment_frame = display_frame();
            d.frame_update  = changed;
            return d;
        endfunction

        function void note_poll(poll_t p);
            pending_displays.push_back(advance_clock(p));
        endfunction

        function void check_display(clock_display_t got);
            clock_display_t want;
            if (pending_displays.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected display beat: hour %0d minute %0d frame %h update %0b",
                             got.hour_value, got.minute_value, got.segment_frame,
                             got.frame_update);
                return;
            end
            want = pending_displays.pop_front();
            if (got.hour_value !== want.hour_value || got.minute_value !== want.minute_value ||
                got.segment_frame !== want.segment_frame ||
                got.frame_update !== want.frame_update) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("display mismatch: expected hour %0d minute %0d frame %h update %0b",
                             want.hour_value, want.minute_value, want.segment_frame,
                             want.frame_update);
                    $display("                  got      hour %0d minute %0d frame %h update %0b",
                             got.hour_value, got.minute_value, got.segment_frame,
                             got.frame_update);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;

    clock_scoreboard time_check = new();

    // pin levels as {a, b} per knob
    logic [1:0] hour_pins;
    logic [1:0] minute_pins;
    int         burst_left;
    int         polls_sent;
    int         tick_pct;

    twelve_hour_clock_with_knob_set dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function bit roll_tick();
        return $urandom_range(0, 99) < tick_pct;
    endfunction

    // one poll beat; the sender pauses between bursts of random length
    task automatic send_poll(input logic [1:0] hp, input logic [1:0] mp, input logic tick);
        poll_t p;
        int    gap;
        p = {tick, mp[0], mp[1], hp[0], hp[1]};
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 20);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {3'b000, p};
        hour_pins   = hp;
        minute_pins = mp;
        do @(posedge aclk); while (!s_tready);
        time_check.note_poll(p);
        burst_left--;
        polls_sent++;
        @(negedge aclk);
    endtask

    // one detent of quadrature, or its first few steps, starting with the knob at rest
    task automatic turn_knob(input bit on_minute, input bit upward, input int steps);
        logic [1:0] path [4];
        if (upward) path = '{2'b10, 2'b11, 2'b01, 2'b00};
        else        path = '{2'b01, 2'b11, 2'b10, 2'b00};
        if (on_minute && minute_pins != 2'b00)
            send_poll(hour_pins, 2'b00, roll_tick());
        else if (!on_minute && hour_pins != 2'b00)
            send_poll(2'b00, minute_pins, roll_tick());
        for (int i = 0; i < steps; i++) begin
            if (on_minute) send_poll(hour_pins, path[i], roll_tick());
            else           send_poll(path[i], minute_pins, roll_tick());
        end
    endtask

    // park the minute at 59 (and optionally the hour at 12), then tick until it rolls
    task automatic roll_minute_over(input bit to_noon);
        tick_pct = 0;
        if (to_noon)
            while (time_check.hour_now != thc_pkg::HOUR_MAX)
                turn_knob(1'b0, time_check.hour_now >= 4'd6, 4);
        while (time_check.minute_now != thc_pkg::MINUTE_MAX)
            turn_knob(1'b1, time_check.minute_now >= 6'd30, 4);
        while (time_check.minute_now == thc_pkg::MINUTE_MAX)
            send_poll(hour_pins, minute_pins, 1'b1);
        tick_pct = 30;
    endtask

    // result side: accept and check every display beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            time_check.check_display(m_tdata[50:0]);
    end

    // receiver stalls on a rotating 8-bit pattern that is reselected at random
    initial begin
        logic [7:0] ready_pattern;
        int         phase;
        m_tready = 1'b0;
        ready_pattern = 8'hff;
        phase = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (phase % 64 == 0)
                ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hff
                                                             : 8'($urandom_range(1, 255));
            m_tready <= ready_pattern[phase % 8];
            phase++;
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        int idle;
        idle = 0;
        wait (aresetn === 1'b1);
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // stimulus
    initial begin
        int         kind;
        int         carries;
        logic [4:0] noise;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        aresetn     = 1'b0;
        hour_pins   = 2'b00;
        minute_pins = 2'b00;
        burst_left  = 0;
        polls_sent  = 0;
        tick_pct    = 0;
        carries     = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // first beat only records the pins: knobs and tick ignored
        send_poll(2'b11, 2'b11, 1'b1);
        send_poll(2'b00, 2'b00, 1'b0);
        // hour wraps 12 -> 1 going up, 1 -> 12 going down
        turn_knob(1'b0, 1'b1, 4);
        turn_knob(1'b0, 1'b0, 4);
        // both channels rise at once on both knobs: steps down, minute 0 -> 59
        send_poll(2'b11, 2'b11, 1'b1);
        send_poll(2'b00, 2'b00, 1'b1);
        // minute wraps 59 -> 0 going up, 0 -> 59 going down
        turn_knob(1'b1, 1'b1, 4);
        turn_knob(1'b1, 1'b0, 4);
        repeat (3) send_poll(2'b00, 2'b00, 1'b1);

        // random turns, tick runs, noise and partial turns
        tick_pct = 30;
        while (polls_sent < POLL_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                turn_knob(1'b0, 1'($urandom_range(0, 1)), 4);
            end else if (kind < 70) begin
                turn_knob(1'b1, 1'($urandom_range(0, 1)), 4);
            end else if (kind < 80) begin
                repeat ($urandom_range(1, 70)) send_poll(hour_pins, minute_pins, 1'b1);
            end else if (kind < 88) begin
                repeat ($urandom_range(1, 6)) begin
                    noise = 5'($urandom);
                    send_poll(noise[4:3], noise[2:1], noise[0]);
                end
            end else if (kind < 95) begin
                turn_knob(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(1, 3));
            end else if (carries < 2) begin
                roll_minute_over(carries == 0);
                carries++;
            end
        end
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        while (time_check.pending_displays.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (time_check.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
